>>> sv/sbal_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sbal_pkg;
    localparam int LIST_COUNT    = 4;
    localparam int CLASS_COUNT   = 10;
    localparam int REGION_BYTES  = 65536;
    localparam int HEADER_BYTES  = 24;
    localparam int NODE_COUNT    = 1024;
    localparam int MIN_BLOCK     = REGION_BYTES / 1024;
    localparam int REGION_CHUNKS = REGION_BYTES / MIN_BLOCK;
    localparam int PAIR_COUNT    = LIST_COUNT * CLASS_COUNT;
    localparam int SMALL_RAW     = MIN_BLOCK << (CLASS_COUNT - 1);
    localparam int SMALL_LIMIT   = (SMALL_RAW > REGION_BYTES / 2) ? REGION_BYTES / 2 : SMALL_RAW;
    localparam int PAIR_W        = $clog2(PAIR_COUNT);
    localparam int CLS_W         = $clog2(CLASS_COUNT + 1);
    localparam int NIDX_W        = $clog2(NODE_COUNT);
    localparam int LINK_W        = NIDX_W + 1;
    localparam int LEFT_W        = $clog2(REGION_CHUNKS + 1);
    localparam int OFF_W         = 33;
    localparam logic [LINK_W-1:0] NODE_NONE = LINK_W'(NODE_COUNT);

    localparam logic CFG_ARENA_BASE  = 1'b0;
    localparam logic CFG_ARENA_BYTES = 1'b1;

    typedef enum logic [1:0] {ST_IDLE, ST_PAIR, ST_NODE} t_state;

    typedef struct packed {
        logic [LINK_W-1:0] head;
        logic [OFF_W-1:0]  cursor;
        logic [LEFT_W-1:0] left;
    } t_pair_ent;

    // smallest class whose block holds s bytes, capped at the top class
    function automatic logic [CLS_W-1:0] class_of(input logic [OFF_W-1:0] s);
        logic [CLS_W-1:0] c;
        c = '0;
        for (int i = 0; i < CLASS_COUNT - 1; i++) begin
            if ((OFF_W'(MIN_BLOCK) << i) < s) c = c + 1'b1;
        end
        return c;
    endfunction
endpackage
`default_nettype wire

>>> sv/sbal_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface sbal_req_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [31:0] request_bytes;
    logic [47:0] block_address;
    logic [31:0] stored_size;
    logic [1:0]  list_id;
    modport source (output valid, mode, request_bytes, block_address, stored_size, list_id,
                    input ready);
    modport sink   (input valid, mode, request_bytes, block_address, stored_size, list_id,
                    output ready);
endinterface
`default_nettype wire

>>> sv/sbal_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface sbal_rsp_if;
    logic        valid;
    logic        ready;
    logic [47:0] user_address;
    logic [31:0] granted_bytes;
    logic        out_of_memory;
    logic        store_full;
    modport source (output valid, user_address, granted_bytes, out_of_memory, store_full,
                    input ready);
    modport sink   (input valid, user_address, granted_bytes, out_of_memory, store_full,
                    output ready);
endinterface
`default_nettype wire

>>> sv/sbal_pair_store.sv
`timescale 1ns / 1ps
`default_nettype none
module sbal_pair_store
    import sbal_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_rd_en,
    input  wire logic [PAIR_W-1:0] i_rd_addr,
    input  wire logic              i_wr_en,
    input  wire logic [PAIR_W-1:0] i_wr_addr,
    input  wire t_pair_ent         i_wr_data,
    output t_pair_ent              o_rd_data
);
    t_pair_ent                r_mem [PAIR_COUNT];
    logic [PAIR_COUNT-1:0]    r_vld;
    t_pair_ent                r_q;
    logic                     r_q_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) r_mem[i_wr_addr] <= i_wr_data;
        if (i_rd_en) r_q <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_q_vld <= 1'b0;
        end else begin
            if (i_wr_en) r_vld[i_wr_addr] <= 1'b1;
            if (i_rd_en) r_q_vld <= r_vld[i_rd_addr];
        end
    end

    // an entry never written reads as empty stack, no carve region
    always_comb begin
        if (r_q_vld) o_rd_data = r_q;
        else o_rd_data = '{head: NODE_NONE, cursor: '0, left: '0};
    end
endmodule
`default_nettype wire

>>> sv/size_class_block_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Payload
// i_req    in   mode, request_bytes, block_address, stored_size, list_id
// o_rsp    out  user_address, granted_bytes, out_of_memory, store_full
// cfg      in   i_cfg_we, i_cfg_idx, i_cfg_data (arena_base, arena_bytes)
//
// An item is accepted in ST_IDLE with the pair-store read, then commits in ST_PAIR. An
// allocation that pops a free stack also passes ST_NODE, since the node store read follows the pair read.
// The next item is taken once the previous one commits into the output register.
// A stalled output holds the commit; no clearing pass, reset is ready at once.
module size_class_block_allocator
    import sbal_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [47:0] i_cfg_data,
    sbal_req_if.sink         i_req,
    sbal_rsp_if.source       o_rsp
);
    localparam int NODE_W = 48 + LINK_W;

    t_state r_state, n_state;

    logic [47:0]       r_arena_base;
    logic [31:0]       r_arena_bytes;
    logic [OFF_W-1:0]  r_bump, n_bump;
    logic [LINK_W-1:0] r_spare, n_spare;
    logic [LINK_W-1:0] r_fresh, n_fresh;

    logic              r_mode;
    logic [OFF_W-1:0]  r_need;
    logic [47:0]       r_baddr;
    logic              r_skip;
    logic              r_small;
    logic [PAIR_W-1:0] r_pair;
    logic [CLS_W-1:0]  r_cls;

    logic [NODE_W-1:0] r_node [NODE_COUNT];
    logic [NODE_W-1:0] r_node_q;

    logic              r_out_valid;
    logic [47:0]       r_out_addr;
    logic [31:0]       r_out_gran;
    logic              r_out_oom;
    logic              r_out_full;

    logic              w_accept;
    logic              w_out_free;
    logic [OFF_W-1:0]  w_need_in;
    logic [CLS_W-1:0]  w_cls_in;
    logic [PAIR_W-1:0] w_pair_in;
    t_pair_ent         w_pair_q;
    logic              w_pair_wr;
    t_pair_ent         w_pair_wd;
    logic              w_node_rd;
    logic [NIDX_W-1:0] w_node_ra;
    logic              w_node_wr;
    logic [NIDX_W-1:0] w_node_wa;
    logic [NODE_W-1:0] w_node_wd;
    logic              w_commit;
    logic [47:0]       w_res_addr;
    logic [31:0]       w_res_gran;
    logic              w_res_oom;
    logic              w_res_full;
    logic [31:0]       w_csize;
    logic [OFF_W-1:0]  w_off;
    logic              w_take;
    logic [OFF_W:0]    w_bump_end;

    assign i_req.ready = (r_state == ST_IDLE) && i_rst_n;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_out_free  = !r_out_valid || o_rsp.ready;

    assign w_need_in = {1'b0, i_req.request_bytes} + OFF_W'(HEADER_BYTES);
    assign w_cls_in  = i_req.mode ? class_of({1'b0, i_req.stored_size}) : class_of(w_need_in);
    assign w_pair_in = PAIR_W'((32'(i_req.list_id) % LIST_COUNT) * CLASS_COUNT + 32'(w_cls_in));
    assign w_csize   = 32'(MIN_BLOCK) << r_cls;

    sbal_pair_store u_pair (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_pair_in),
        .i_wr_en   (w_pair_wr),
        .i_wr_addr (r_pair),
        .i_wr_data (w_pair_wd),
        .o_rd_data (w_pair_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_rst_n && i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ARENA_BASE:  r_arena_base <= i_cfg_data;
                CFG_ARENA_BYTES: r_arena_bytes <= i_cfg_data[31:0];
                default: ;
            endcase
        end
        if (!i_rst_n) begin
            r_arena_base  <= '0;
            r_arena_bytes <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode  <= i_req.mode;
            r_need  <= w_need_in;
            r_baddr <= i_req.block_address;
            r_skip  <= (i_req.block_address == '0) || (i_req.stored_size == '0)
                       || ({1'b0, i_req.stored_size} > OFF_W'(SMALL_LIMIT));
            r_small <= (w_need_in <= OFF_W'(SMALL_LIMIT));
            r_pair  <= w_pair_in;
            r_cls   <= w_cls_in;
        end
        if (w_node_wr) r_node[w_node_wa] <= w_node_wd;
        if (w_node_rd) r_node_q <= r_node[w_node_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_bump      <= '0;
            r_spare     <= '0;
            r_fresh     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bump  <= n_bump;
            r_spare <= n_spare;
            r_fresh <= n_fresh;
            if (w_commit) r_out_valid <= 1'b1;
            else if (o_rsp.ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_addr <= w_res_addr;
            r_out_gran <= w_res_gran;
            r_out_oom  <= w_res_oom;
            r_out_full <= w_res_full;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.user_address  = r_out_addr;
    assign o_rsp.granted_bytes = r_out_gran;
    assign o_rsp.out_of_memory = r_out_oom;
    assign o_rsp.store_full    = r_out_full;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_PAIR;
            ST_PAIR: begin
                if (!r_mode && r_small && (w_pair_q.head != NODE_NONE)) n_state = ST_NODE;
                else if (w_out_free) n_state = ST_IDLE;
            end
            ST_NODE: if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_commit   = 1'b0;
        w_pair_wr  = 1'b0;
        w_pair_wd  = w_pair_q;
        w_node_rd  = 1'b0;
        w_node_ra  = r_spare[NIDX_W-1:0];
        w_node_wr  = 1'b0;
        w_node_wa  = r_spare[NIDX_W-1:0];
        w_node_wd  = {r_baddr, w_pair_q.head};
        w_res_addr = '0;
        w_res_gran = '0;
        w_res_oom  = 1'b0;
        w_res_full = 1'b0;
        w_off      = r_bump;
        w_take     = 1'b0;
        w_bump_end = '0;
        n_bump     = r_bump;
        n_spare    = r_spare;
        n_fresh    = r_fresh;
        unique case (r_state)
            ST_IDLE: begin
                // fetch link of the spare head for a free
                w_node_rd = w_accept;
            end
            ST_PAIR: begin
                if (r_mode) begin
                    w_commit = w_out_free;
                    if (r_skip) begin
                        w_res_full = 1'b0;
                    end else if (r_spare == NODE_NONE) begin
                        w_res_full = 1'b1;
                    end else begin
                        w_node_wr      = w_commit;
                        w_pair_wr      = w_commit;
                        w_pair_wd.head = r_spare;
                        if (w_commit) begin
                            // never handed out: its link is still the next index
                            if (r_spare == r_fresh) begin
                                n_spare = r_spare + 1'b1;
                                n_fresh = r_fresh + 1'b1;
                            end else begin
                                n_spare = r_node_q[LINK_W-1:0];
                            end
                        end
                    end
                end else if (r_small && (w_pair_q.head != NODE_NONE)) begin
                    w_node_rd = 1'b1;
                    w_node_ra = w_pair_q.head[NIDX_W-1:0];
                end else begin
                    w_commit = w_out_free;
                    if (r_small) begin
                        if (w_pair_q.left != '0) begin
                            w_off            = w_pair_q.cursor;
                            w_take           = 1'b1;
                            w_pair_wd.cursor = w_pair_q.cursor + OFF_W'(w_csize);
                            w_pair_wd.left   = w_pair_q.left - 1'b1;
                        end else begin
                            w_bump_end = {1'b0, r_bump} + (OFF_W + 1)'(REGION_BYTES);
                            if (w_bump_end < (OFF_W + 1)'(r_arena_bytes)) begin
                                w_take           = 1'b1;
                                n_bump           = w_bump_end[OFF_W-1:0];
                                w_pair_wd.cursor = r_bump + OFF_W'(w_csize);
                                w_pair_wd.left   = LEFT_W'(REGION_CHUNKS >> r_cls) - 1'b1;
                            end
                        end
                        w_res_gran = w_csize;
                    end else begin
                        w_bump_end = {1'b0, r_bump} + {1'b0, r_need};
                        if (w_bump_end < (OFF_W + 1)'(r_arena_bytes)) begin
                            w_take = 1'b1;
                            n_bump = w_bump_end[OFF_W-1:0];
                        end
                        w_res_gran = r_need[31:0];
                    end
                    if (w_take) begin
                        w_pair_wr  = w_commit && r_small;
                        w_res_addr = r_arena_base + 48'(w_off) + 48'(HEADER_BYTES);
                    end else begin
                        w_res_gran = '0;
                        w_res_oom  = 1'b1;
                    end
                    if (!w_commit) n_bump = r_bump;
                end
            end
            ST_NODE: begin
                // pop: head moves to the link, the node returns to the spare list
                w_commit       = w_out_free;
                w_pair_wr      = w_commit;
                w_pair_wd.head = r_node_q[LINK_W-1:0];
                w_node_wr      = w_commit;
                w_node_wa      = w_pair_q.head[NIDX_W-1:0];
                w_node_wd      = {r_node_q[NODE_W-1:LINK_W], r_spare};
                w_res_addr     = r_node_q[NODE_W-1:LINK_W];
                w_res_gran     = w_csize;
                if (w_commit) n_spare = w_pair_q.head;
            end
            default: ;
        endcase
    end

    a_fresh_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_fresh >= $past(r_fresh))
        else $error("fresh node count went backward");

    a_spare_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_spare <= r_fresh)
        else $error("spare head beyond fresh node count");

    a_bump_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bump != $past(r_bump)) && $past(i_rst_n) |-> r_bump < {1'b0, r_arena_bytes})
        else $error("bump offset reached arena end");

    a_oom_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit && w_res_oom |-> (w_res_addr == '0) && (w_res_gran == '0) && !w_take)
        else $error("out of memory result carries an allocation");
endmodule
`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps
module tb;
    import sbal_pkg::*;

    typedef struct packed {
        logic [47:0] user_address;
        logic [31:0] granted_bytes;
        logic        out_of_memory;
        logic        store_full;
    } t_grant;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = CFG_ARENA_BASE;
    logic [47:0] i_cfg_data = '0;

    sbal_req_if req_ch();
    sbal_rsp_if rsp_ch();

    size_class_block_allocator u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch.sink),
        .o_rsp      (rsp_ch.source)
    );

    always #6 i_clk = ~i_clk;

    // shadow allocator state
    logic [47:0] base_addr;
    logic [32:0] arena_size;
    logic [32:0] bump;
    int unsigned heads [PAIR_COUNT];
    logic [32:0] cursor [PAIR_COUNT];
    int unsigned chunks_left [PAIR_COUNT];
    logic [47:0] node_addr [NODE_COUNT];
    int unsigned node_next [NODE_COUNT];
    int unsigned spare;

    t_grant      grants_due[$];
    logic [47:0] live_blocks[$];
    logic [31:0] live_sizes[$];
    logic [1:0]  live_lists[$];
    int          failures = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          recv_hold = 1'b0;
    int          idle_cycles = 0;

    initial begin
        req_ch.valid = 1'b0;
        req_ch.mode = 1'b0;
        req_ch.request_bytes = '0;
        req_ch.block_address = '0;
        req_ch.stored_size = '0;
        req_ch.list_id = '0;
        rsp_ch.ready = 1'b0;
    end

    function automatic int unsigned size_class(input logic [32:0] s);
        int unsigned c;
        c = 0;
        while (c + 1 < CLASS_COUNT && (33'(MIN_BLOCK) << c) < s) c++;
        return c;
    endfunction

    function automatic void shadow_reset();
        base_addr = '0;
        arena_size = '0;
        bump = '0;
        for (int i = 0; i < PAIR_COUNT; i++) begin
            heads[i] = NODE_COUNT;
            cursor[i] = '0;
            chunks_left[i] = 0;
        end
        for (int i = 0; i < NODE_COUNT; i++) begin
            node_addr[i] = '0;
            node_next[i] = i + 1;
        end
        spare = 0;
    endfunction

    function automatic t_grant allocate_or_free(input logic m, input logic [31:0] req,
                                                input logic [47:0] baddr,
                                                input logic [31:0] ssize,
                                                input logic [1:0] lid);
        t_grant      g;
        int unsigned pair, n, cls;
        logic [32:0] need, csize, off;
        g = '0;
        if (m) begin
            if (baddr == 0 || ssize == 0 || ssize > SMALL_LIMIT) return g;
            if (spare >= NODE_COUNT) begin
                g.store_full = 1'b1;
                return g;
            end
            pair = (lid % LIST_COUNT) * CLASS_COUNT + size_class({1'b0, ssize});
            n = spare;
            spare = node_next[n];
            node_addr[n] = baddr;
            node_next[n] = heads[pair];
            heads[pair] = n;
            return g;
        end
        need = {1'b0, req} + HEADER_BYTES;
        if (need <= SMALL_LIMIT) begin
            cls = size_class(need);
            pair = (lid % LIST_COUNT) * CLASS_COUNT + cls;
            csize = 33'(MIN_BLOCK) << cls;
            n = heads[pair];
            if (n < NODE_COUNT) begin
                heads[pair] = node_next[n];
                node_next[n] = spare;
                spare = n;
                g.user_address = node_addr[n];
                g.granted_bytes = csize[31:0];
                return g;
            end
            if (chunks_left[pair] != 0) begin
                off = cursor[pair];
                cursor[pair] = off + csize;
                chunks_left[pair]--;
            end else begin
                if ({1'b0, bump} + REGION_BYTES >= {1'b0, arena_size}) begin
                    g.out_of_memory = 1'b1;
                    return g;
                end
                off = bump;
                bump = bump + REGION_BYTES;
                cursor[pair] = off + csize;
                chunks_left[pair] = REGION_BYTES / csize - 1;
            end
            g.user_address = base_addr + off + HEADER_BYTES;
            g.granted_bytes = csize[31:0];
            return g;
        end
        if ({1'b0, bump} + {1'b0, need} >= {1'b0, arena_size}) begin
            g.out_of_memory = 1'b1;
            return g;
        end
        off = bump;
        bump = bump + need;
        g.user_address = base_addr + off + HEADER_BYTES;
        g.granted_bytes = need[31:0];
        return g;
    endfunction

    // valid stays up after the word; an idle gap in the next send or a drain lowers it
    task automatic send_word(input logic m, input logic [31:0] req, input logic [47:0] baddr,
                             input logic [31:0] ssize, input logic [1:0] lid);
        t_grant g;
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.mode <= m;
        req_ch.request_bytes <= req;
        req_ch.block_address <= baddr;
        req_ch.stored_size <= ssize;
        req_ch.list_id <= lid;
        do @(posedge i_clk); while (!req_ch.ready);
        g = allocate_or_free(m, req, baddr, ssize, lid);
        grants_due.push_back(g);
        if (!m && g.granted_bytes != 0 && !g.out_of_memory &&
            g.granted_bytes <= SMALL_LIMIT) begin
            live_blocks.push_back(g.user_address);
            live_sizes.push_back(g.granted_bytes);
            live_lists.push_back(lid);
        end
    endtask

    task automatic alloc(input logic [31:0] req, input logic [1:0] lid);
        send_word(1'b0, req, 48'($urandom), 32'($urandom), lid);
    endtask

    task automatic free_block(input logic [47:0] baddr, input logic [31:0] ssize,
                              input logic [1:0] lid);
        send_word(1'b1, 32'($urandom), baddr, ssize, lid);
    endtask

    task automatic free_live();
        int k;
        k = $urandom_range(live_blocks.size() - 1);
        free_block(live_blocks[k], live_sizes[k], live_lists[k]);
        live_blocks.delete(k);
        live_sizes.delete(k);
        live_lists.delete(k);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (grants_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [47:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_ARENA_BASE) base_addr = value;
        else arena_size = {1'b0, value[31:0]};
    endtask

    always @(posedge i_clk) begin
        if (recv_hold) rsp_ch.ready <= 1'b0;
        else rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_grant g;
        if (rsp_ch.valid && rsp_ch.ready) begin
            if (grants_due.size() == 0) begin
                $error("unexpected response word");
                failures++;
            end else begin
                g = grants_due.pop_front();
                if (rsp_ch.user_address !== g.user_address) begin
                    $error("user_address exp %h got %h", g.user_address, rsp_ch.user_address);
                    failures++;
                end
                if (rsp_ch.granted_bytes !== g.granted_bytes) begin
                    $error("granted_bytes exp %h got %h", g.granted_bytes,
                           rsp_ch.granted_bytes);
                    failures++;
                end
                if (rsp_ch.out_of_memory !== g.out_of_memory) begin
                    $error("out_of_memory exp %b got %b", g.out_of_memory,
                           rsp_ch.out_of_memory);
                    failures++;
                end
                if (rsp_ch.store_full !== g.store_full) begin
                    $error("store_full exp %b got %b", g.store_full, rsp_ch.store_full);
                    failures++;
                end
            end
        end
    end

    // watchdog on accepted words
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic test_directed();
        write_reg(CFG_ARENA_BASE, 48'h0000_1000_0000);
        write_reg(CFG_ARENA_BYTES, 48'h0000_0040_0000);
        alloc(32'd0, 2'd0);
        alloc(32'd40, 2'd0);
        alloc(32'd41, 2'd3);
        alloc(32'd32744, 2'd1);
        alloc(32'd32745, 2'd1);
        alloc(32'hFFFF_FFFF, 2'd2);
        alloc(32'hFFFF_FFE8, 2'd2);
        free_block(48'd0, 32'd64, 2'd0);
        free_block(48'hFFFF_FFFF_FFFF, 32'd0, 2'd0);
        free_block(48'h1234, 32'd32769, 2'd0);
        free_block(48'hFFFF_FFFF_FFFF, 32'd32768, 2'd3);
        free_block(48'h5555, 32'd65, 2'd1);
        free_block(48'hAAAA_AAAA_AAAA, 32'd1, 2'd2);
        alloc(32'd100, 2'd1);
        alloc(32'd32744, 2'd3);
        alloc(32'd10, 2'd2);
        alloc(32'd10, 2'd2);
        drain();
        // empty arena: the large allocation runs out; the small one carves its open region
        write_reg(CFG_ARENA_BYTES, 48'h0);
        write_reg(CFG_ARENA_BASE, 48'hFFFF_FFFF_FFFF);
        alloc(32'd0, 2'd0);
        alloc(32'd100000, 2'd1);
        drain();
    endtask

    task automatic test_random(input int count);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 45) alloc(32'($urandom_range(2000)), 2'($urandom));
            else if (r < 55) alloc(32'($urandom_range(32744)), 2'($urandom));
            else if (r < 58) alloc($urandom, 2'($urandom));
            else if (r < 88 && live_blocks.size() != 0) free_live();
            else if (r < 94) free_block(48'($urandom) << $urandom_range(16),
                                        32'($urandom_range(32768)), 2'($urandom));
            else free_block(48'({$urandom, $urandom}), $urandom, 2'($urandom));
        end
        drain();
    endtask

    // fill the node store so frees overflow
    task automatic test_store_full();
        for (int i = 0; i < NODE_COUNT + 20; i++)
            free_block(48'(i + 1), 32'($urandom_range(1, SMALL_LIMIT)), 2'($urandom));
        for (int i = 0; i < 60; i++) alloc(32'($urandom_range(40)), 2'($urandom));
        drain();
    endtask

    task automatic test_backpressure();
        fork
            begin
                recv_hold = 1'b1;
                repeat (300) @(posedge i_clk);
                recv_hold = 1'b0;
            end
            begin
                for (int i = 0; i < 30; i++) alloc(32'($urandom_range(500)), 2'($urandom));
                req_ch.valid <= 1'b0;
            end
        join
        drain();
    endtask

    initial begin
        shadow_reset();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 15;
        recv_idle_pct = 86;
        test_directed();
        write_reg(CFG_ARENA_BASE, 48'({$urandom, $urandom}));
        write_reg(CFG_ARENA_BYTES, 48'h0100_0000);
        test_random(100);
        test_backpressure();
        write_reg(CFG_ARENA_BYTES, 48'h0000_FFFF_FFFF);
        send_idle_pct = 86;
        recv_idle_pct = 15;
        test_random(100);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_store_full();
        write_reg(CFG_ARENA_BYTES, 48'h0004_0000);
        test_random(100);
        if (failures == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end
endmodule
